// ----- hdl/assert_macros.svh -----
// Assertion helpers, clocked on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SMM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/smm_pkg.sv -----
`default_nettype none
package smm_pkg;
    localparam int MAX_DIM_DEF = 8;
    localparam int SUM_W       = 35;

    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [2:0] REG_A_ROWS = 3'd0;
    localparam logic [2:0] REG_A_COLS = 3'd1;
    localparam logic [2:0] REG_B_ROWS = 3'd2;
    localparam logic [2:0] REG_B_COLS = 3'd3;
    localparam logic [2:0] REG_ALPHA  = 3'd4;
    localparam logic [2:0] REG_BETA   = 3'd5;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [15:0] value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] product;
        logic               last;
    } result_t;

    typedef struct packed {
        logic               a_en;
        logic               b_en;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [15:0] value;
    } wr_bus_t;

    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic [2:0]              row;
        logic [2:0]              col;
        logic signed [SUM_W-1:0] sum;
    } cell_bus_t;
endpackage
`default_nettype wire

// ----- hdl/smm_cell.sv -----
`default_nettype none
module smm_cell #(
    parameter int MAX_DIM = 8,
    parameter int K       = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire smm_pkg::wr_bus_t  wr,
    input  wire logic [3:0]        nk,
    input  wire smm_pkg::cell_bus_t bus_in,
    output smm_pkg::cell_bus_t     bus_out
);
    import smm_pkg::*;
    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic signed [15:0] a_mem [MAX_DIM];
    logic signed [15:0] b_mem [MAX_DIM];
    logic signed [15:0] a_q_reg;
    logic signed [15:0] b_q_reg;
    cell_bus_t          mid_reg;
    cell_bus_t          out_reg;
    cell_bus_t          out_next;
    logic signed [31:0] prod;
    logic               active;

    always_ff @(posedge clk)
    begin
        if (wr.a_en && wr.col == 3'(K) && {1'b0, wr.row} < 4'(MAX_DIM))
        begin
            a_mem[wr.row[IW-1:0]] <= wr.value;
        end
        if (wr.b_en && wr.row == 3'(K) && {1'b0, wr.col} < 4'(MAX_DIM))
        begin
            b_mem[wr.col[IW-1:0]] <= wr.value;
        end
        a_q_reg <= a_mem[bus_in.row[IW-1:0]];
        b_q_reg <= b_mem[bus_in.col[IW-1:0]];
    end

    assign active = 4'(K) < nk;
    assign prod   = active ? (32'(a_q_reg) * 32'(b_q_reg)) : 32'sd0;

    always_comb
    begin
        out_next     = mid_reg;
        out_next.sum = mid_reg.sum + SUM_W'(prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            mid_reg <= bus_in;
            out_reg <= out_next;
        end
    end

    assign bus_out = out_reg;
endmodule
`default_nettype wire

// ----- hdl/smm_scale.sv -----
`default_nettype none
module smm_scale (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire smm_pkg::cell_bus_t bus_in,
    input  wire logic signed [31:0] scale,
    input  wire logic               match,
    output logic                    strobe,
    output smm_pkg::result_t        result
);
    import smm_pkg::*;
    localparam int HI_W = SUM_W - 16;
    localparam int FW   = SUM_W + 33;

    logic               v1_reg, v2_reg, v3_reg;
    logic               l1_reg, l2_reg;
    logic [2:0]         r1_reg, r2_reg, c1_reg, c2_reg;
    logic signed [48:0] lo_reg;
    logic signed [HI_W+31:0] hi_reg;
    logic signed [FW-1:0]    full_reg;
    logic signed [FW-17:0]   q;
    logic signed [31:0]      sat;
    result_t                 res_reg;

    assign q = full_reg[FW-1:16];

    always_comb
    begin
        if (q > (FW-16)'(33'sh0_7FFF_FFFF))
        begin
            sat = 32'sh7FFF_FFFF;
        end
        else if (q < -(FW-16)'(33'sh0_8000_0000))
        begin
            sat = 32'sh8000_0000;
        end
        else
        begin
            sat = q[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= bus_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= $signed({1'b0, bus_in.sum[15:0]}) * scale;
        hi_reg   <= $signed(bus_in.sum[SUM_W-1:16]) * scale;
        l1_reg   <= bus_in.last;
        r1_reg   <= bus_in.row;
        c1_reg   <= bus_in.col;
        full_reg <= (FW'(hi_reg) <<< 16) + FW'(lo_reg);
        l2_reg   <= l1_reg;
        r2_reg   <= r1_reg;
        c2_reg   <= c1_reg;
        res_reg.out_row <= r2_reg;
        res_reg.out_col <= c2_reg;
        res_reg.product <= match ? sat : 32'sd0;
        res_reg.last    <= l2_reg;
    end

    assign strobe = v3_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

// ----- hdl/scaled_matrix_multiply_unit.sv -----
// Element writes do not leave idle; busy stays low.
// A compute transaction issues one product element per cycle into a chain of MAX_DIM
// two-stage MAC cells, then three scaling stages; busy stays high until the last result
// is strobed, and after the first result there is one result per cycle.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset clears control and registers to defaults; matrix contents are undefined until written.
`default_nettype none
module scaled_matrix_multiply_unit #(
    parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire smm_pkg::cmd_t    cmd,
    output logic                  strobe,
    output smm_pkg::result_t      result,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import smm_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic signed [15:0] alpha_reg, beta_reg;
    logic [3:0]         nr_reg, nc_reg, nk_reg;
    logic               match_reg;
    logic signed [31:0] scale_reg;
    logic [2:0]         i_reg, j_reg;
    logic               accept, cfg_wr, row_end, col_end;
    logic [2:0]         reg_idx;
    wr_bus_t            wr;
    cell_bus_t          chain [MAX_DIM+1];

    function automatic logic [3:0] clamp_dim(input logic [3:0] v);
        if (v == 4'd0)
        begin
            return 4'd1;
        end
        else if (v > 4'(MAX_DIM))
        begin
            return 4'(MAX_DIM);
        end
        return v;
    endfunction

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= 4'd8;
            a_cols_reg <= 4'd8;
            b_rows_reg <= 4'd8;
            b_cols_reg <= 4'd8;
            alpha_reg  <= 16'sd256;
            beta_reg   <= 16'sd256;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_A_ROWS: a_rows_reg <= pwdata[3:0];
                REG_A_COLS: a_cols_reg <= pwdata[3:0];
                REG_B_ROWS: b_rows_reg <= pwdata[3:0];
                REG_B_COLS: b_cols_reg <= pwdata[3:0];
                REG_ALPHA:  alpha_reg  <= pwdata[15:0];
                REG_BETA:   beta_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_A_ROWS: prdata = {28'd0, a_rows_reg};
            REG_A_COLS: prdata = {28'd0, a_cols_reg};
            REG_B_ROWS: prdata = {28'd0, b_rows_reg};
            REG_B_COLS: prdata = {28'd0, b_cols_reg};
            REG_ALPHA:  prdata = {16'd0, alpha_reg};
            REG_BETA:   prdata = {16'd0, beta_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;

    assign wr.a_en  = accept && cmd.opcode == OP_WRITE_A;
    assign wr.b_en  = accept && cmd.opcode == OP_WRITE_B;
    assign wr.row   = cmd.row;
    assign wr.col   = cmd.col;
    assign wr.value = cmd.value;

    assign row_end = {1'b0, i_reg} + 4'd1 == nr_reg;
    assign col_end = {1'b0, j_reg} + 4'd1 == nc_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.opcode == OP_COMPUTE)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (row_end && col_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (strobe && result.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= 3'd0;
            j_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ISSUE)
            begin
                if (row_end)
                begin
                    i_reg <= 3'd0;
                    j_reg <= col_end ? 3'd0 : j_reg + 3'd1;
                end
                else
                begin
                    i_reg <= i_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.opcode == OP_COMPUTE)
        begin
            nr_reg    <= clamp_dim(a_rows_reg);
            nc_reg    <= clamp_dim(b_cols_reg);
            nk_reg    <= clamp_dim(a_cols_reg);
            match_reg <= clamp_dim(a_cols_reg) == clamp_dim(b_rows_reg);
            scale_reg <= alpha_reg * beta_reg;
        end
    end

    assign chain[0].valid = state_reg == ST_ISSUE;
    assign chain[0].last  = row_end && col_end;
    assign chain[0].row   = i_reg;
    assign chain[0].col   = j_reg;
    assign chain[0].sum   = '0;

    for (genvar k = 0; k < MAX_DIM; k++)
    begin : g_cell
        smm_cell #(
            .MAX_DIM(MAX_DIM),
            .K      (k)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .wr     (wr),
            .nk     (nk_reg),
            .bus_in (chain[k]),
            .bus_out(chain[k+1])
        );
    end

    smm_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .bus_in(chain[MAX_DIM]),
        .scale (scale_reg),
        .match (match_reg),
        .strobe(strobe),
        .result(result)
    );

    `SMM_ASSERT_NOW(a_strobe_busy, strobe, busy, "result while idle")
    `SMM_ASSERT_NEXT(a_compute_busy, accept && cmd.opcode == OP_COMPUTE, busy, "compute not busy")
    `SMM_ASSERT_NEXT(a_last_idle, strobe && result.last, !busy, "busy after last result")
    `SMM_ASSERT_NOW(a_issue_bounds, state_reg == ST_ISSUE, {1'b0, i_reg} < nr_reg, "row overrun")
endmodule
`default_nettype wire
